@@ design/srrw_pkg.sv @@
// Shared types and constants of the selective-repeat receive window.
// Used by the channel interfaces, the modular unit, the slot store and the top level.
package srrw_pkg;

    localparam int WINDOW    = 12;
    localparam int SEQ_SPACE = 100;

    localparam int SEQ_W    = 7;
    localparam int HANDLE_W = 16;
    localparam int LENGTH_W = 14;
    localparam int KIND_W   = 2;

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int BASE_W = (SEQ_SPACE > 1) ? $clog2(SEQ_SPACE) : 1;
    localparam int MOD_W  = $clog2(SEQ_SPACE + 1);
    localparam int UNIT_W = (MOD_W > SEQ_W) ? MOD_W : SEQ_W;

    localparam logic [KIND_W-1:0] KIND_ACK     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIN     = 2'd2;

    // request to the shared modular add/subtract unit
    typedef struct packed {
        logic              sub;
        logic [UNIT_W-1:0] a;
        logic [UNIT_W-1:0] b;
        logic [UNIT_W-1:0] m;
    } t_alu_req;

    typedef struct packed {
        logic                wr_en;
        logic [SLOT_W-1:0]   wr_slot;
        logic [HANDLE_W-1:0] wr_handle;
        logic [LENGTH_W-1:0] wr_length;
        logic                clr_all;
        logic                clr_en;
        logic [SLOT_W-1:0]   clr_slot;
        logic [SLOT_W-1:0]   rd_slot;
    } t_store_cmd;

    typedef struct packed {
        logic [WINDOW-1:0]   filled;
        logic [HANDLE_W-1:0] handle;
        logic [LENGTH_W-1:0] length;
    } t_store_rsp;

endpackage

@@ design/srrw_in_if.sv @@
// Packet header channel of the receive window.
// Depends on srrw_pkg for field widths.
interface srrw_in_if import srrw_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SEQ_W-1:0]    pkt_seq;
    logic                checksum_ok;
    logic                end_of_file;
    logic [HANDLE_W-1:0] payload_handle;
    logic [LENGTH_W-1:0] payload_length;

    modport source (
        output valid, pkt_seq, checksum_ok, end_of_file, payload_handle, payload_length,
        input  ready
    );
    modport sink (
        input  valid, pkt_seq, checksum_ok, end_of_file, payload_handle, payload_length,
        output ready
    );
endinterface

@@ design/srrw_out_if.sv @@
// Result channel of the receive window: acknowledgments, deliveries, fin.
// Depends on srrw_pkg for field widths.
interface srrw_out_if import srrw_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [SEQ_W-1:0]    ack_seq;
    logic [HANDLE_W-1:0] out_handle;
    logic [LENGTH_W-1:0] out_length;
    logic                last;

    modport source (
        output valid, kind, ack_seq, out_handle, out_length, last,
        input  ready
    );
    modport sink (
        input  valid, kind, ack_seq, out_handle, out_length, last,
        output ready
    );
endinterface

@@ design/srrw_mod_unit.sv @@
// Shared modular add/subtract unit: (a + b) mod m or (a - b) mod m,
// operands below m. Depends on srrw_pkg.
module srrw_mod_unit import srrw_pkg::*; (
    input  t_alu_req          i_req,
    output logic [UNIT_W-1:0] o_res
);

    logic [UNIT_W:0] w_t;
    logic [UNIT_W:0] w_fix;
    logic            w_wrap;

    always_comb begin
        w_t    = i_req.sub ? ({1'b0, i_req.a} - {1'b0, i_req.b})
                           : ({1'b0, i_req.a} + {1'b0, i_req.b});
        // borrow on subtract, sum at or above the modulus on add
        w_wrap = i_req.sub ? w_t[UNIT_W] : (w_t >= {1'b0, i_req.m});
        w_fix  = i_req.sub ? (w_t + {1'b0, i_req.m}) : (w_t - {1'b0, i_req.m});
        o_res  = w_wrap ? w_fix[UNIT_W-1:0] : w_t[UNIT_W-1:0];
    end

endmodule

@@ design/srrw_slot_store.sv @@
// Window slot store: filled bits in flops, handle and length memories
// with a registered read port. Depends on srrw_pkg.
module srrw_slot_store import srrw_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_store_cmd i_cmd,
    output t_store_rsp o_rsp
);

    logic [HANDLE_W-1:0] r_mem_handle [WINDOW];
    logic [LENGTH_W-1:0] r_mem_length [WINDOW];
    logic [WINDOW-1:0]   r_filled;
    logic [HANDLE_W-1:0] r_rd_handle;
    logic [LENGTH_W-1:0] r_rd_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled <= '0;
        end else if (i_cmd.clr_all) begin
            r_filled <= '0;
        end else begin
            if (i_cmd.clr_en) begin
                r_filled[i_cmd.clr_slot] <= 1'b0;
            end
            if (i_cmd.wr_en) begin
                r_filled[i_cmd.wr_slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem_handle[i_cmd.wr_slot] <= i_cmd.wr_handle;
            r_mem_length[i_cmd.wr_slot] <= i_cmd.wr_length;
        end
        r_rd_handle <= r_mem_handle[i_cmd.rd_slot];
        r_rd_length <= r_mem_length[i_cmd.rd_slot];
    end

    assign o_rsp.filled = r_filled;
    assign o_rsp.handle = r_rd_handle;
    assign o_rsp.length = r_rd_length;

endmodule

@@ design/selective_repeat_receive_window_top.sv @@
// Selective-repeat receive window, top level with the step sequencer.
// Depends on srrw_pkg, srrw_in_if, srrw_out_if, srrw_mod_unit, srrw_slot_store.
//
// Usage:
//   i_in carries one received packet header per transfer; o_out carries the
//   results it causes: an acknowledgment, then in-order deliveries, or a single
//   fin acknowledgment. last marks the final result of a header.
//   Ready on i_in is high only while the sequencer is idle; one header is
//   worked on at a time.
//   Steps: a header with a bad checksum is dropped and gives nothing. An
//   end-of-file header goes to the fin step. A data header goes through the
//   offset, slot and acknowledgment steps, then a delivery and a base update
//   per slot delivered (at most WINDOW). The single modular adder does one
//   offset, slot, head or base update per cycle while the result sink does
//   not stall, and the slot memory has a registered read.
//   Reset (synchronous, active low) empties the window and returns base and
//   head to zero; no clearing pass is needed.
//   When the result sink stalls, the held result stays in the output register
//   and the sequencer waits; no result is dropped.
module selective_repeat_receive_window_top import srrw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    srrw_in_if.sink    i_in,
    srrw_out_if.source o_out
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FIN  = 3'd1;
    localparam logic [2:0] S_OFF  = 3'd2;
    localparam logic [2:0] S_SLOT = 3'd3;
    localparam logic [2:0] S_ACK  = 3'd4;
    localparam logic [2:0] S_DLV  = 3'd5;
    localparam logic [2:0] S_BASE = 3'd6;

    logic [2:0]          r_state, n_state;
    logic [SEQ_W-1:0]    r_seq;
    logic                r_eof;
    logic                r_good;
    logic [HANDLE_W-1:0] r_handle;
    logic [LENGTH_W-1:0] r_length;
    logic [BASE_W-1:0]   r_base, n_base;
    logic [SLOT_W-1:0]   r_head, n_head;
    logic [UNIT_W-1:0]   r_offset, n_offset;

    logic                r_ovalid;
    logic [KIND_W-1:0]   r_okind, n_okind;
    logic [SEQ_W-1:0]    r_oack, n_oack;
    logic [HANDLE_W-1:0] r_ohandle, n_ohandle;
    logic [LENGTH_W-1:0] r_olength, n_olength;
    logic                r_olast, n_olast;

    t_alu_req          w_req;
    logic [UNIT_W-1:0] w_res;
    t_store_cmd        w_cmd;
    t_store_rsp        w_rsp;
    logic              w_out_free;
    logic              w_load;
    logic              w_accept;
    logic              w_in_win;
    logic [SLOT_W-1:0] w_next_head;

    srrw_mod_unit u_unit (
        .i_req (w_req),
        .o_res (w_res)
    );

    srrw_slot_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_rsp   (w_rsp)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_out_free  = !r_ovalid || o_out.ready;
    assign w_next_head = SLOT_W'(w_res);
    assign w_in_win    = (UNIT_W'(r_seq) < UNIT_W'(SEQ_SPACE))
                         && (r_offset < UNIT_W'(WINDOW));

    always_comb begin
        n_state   = r_state;
        n_base    = r_base;
        n_head    = r_head;
        n_offset  = r_offset;
        w_load    = 1'b0;
        n_okind   = KIND_ACK;
        n_oack    = '0;
        n_ohandle = '0;
        n_olength = '0;
        n_olast   = 1'b0;

        w_req.sub = 1'b0;
        w_req.a   = UNIT_W'(r_base);
        w_req.b   = UNIT_W'(1);
        w_req.m   = UNIT_W'(SEQ_SPACE);

        w_cmd.wr_en     = 1'b0;
        w_cmd.wr_slot   = w_next_head;
        w_cmd.wr_handle = r_handle;
        w_cmd.wr_length = r_length;
        w_cmd.clr_all   = 1'b0;
        w_cmd.clr_en    = 1'b0;
        w_cmd.clr_slot  = r_head;
        w_cmd.rd_slot   = r_head;

        unique case (r_state)
            S_IDLE: begin
                n_state = S_IDLE;
            end
            S_FIN: begin
                if (w_out_free) begin
                    w_load        = 1'b1;
                    n_okind       = KIND_FIN;
                    n_olast       = 1'b1;
                    w_cmd.clr_all = 1'b1;
                    n_base        = '0;
                    n_head        = '0;
                    n_state       = S_IDLE;
                end
            end
            S_OFF: begin
                // offset of the packet ahead of the window base
                w_req.sub = 1'b1;
                w_req.a   = UNIT_W'(r_seq);
                w_req.b   = UNIT_W'(r_base);
                w_req.m   = UNIT_W'(SEQ_SPACE);
                n_offset  = w_res;
                n_state   = S_SLOT;
            end
            S_SLOT: begin
                w_req.a     = UNIT_W'(r_head);
                w_req.b     = r_offset;
                w_req.m     = UNIT_W'(WINDOW);
                w_cmd.wr_en = w_in_win;
                n_state     = S_ACK;
            end
            S_ACK: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_okind = KIND_ACK;
                    n_oack  = r_seq;
                    n_olast = !w_rsp.filled[r_head];
                    n_state = w_rsp.filled[r_head] ? S_DLV : S_IDLE;
                end
            end
            S_DLV: begin
                w_req.a = UNIT_W'(r_head);
                w_req.b = UNIT_W'(1);
                w_req.m = UNIT_W'(WINDOW);
                if (w_out_free) begin
                    w_load       = 1'b1;
                    n_okind      = KIND_DELIVER;
                    n_ohandle    = w_rsp.handle;
                    n_olength    = w_rsp.length;
                    // the slot being freed does not count as the next one
                    n_olast      = !(w_rsp.filled[w_next_head] && (w_next_head != r_head));
                    w_cmd.clr_en = 1'b1;
                    n_head       = w_next_head;
                    n_state      = S_BASE;
                end
            end
            S_BASE: begin
                n_base  = BASE_W'(w_res);
                n_state = w_rsp.filled[r_head] ? S_DLV : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_accept) begin
            if (!i_in.checksum_ok) begin
                n_state = S_IDLE;
            end else if (i_in.end_of_file) begin
                n_state = S_FIN;
            end else begin
                n_state = S_OFF;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_base   <= '0;
            r_head   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_base  <= n_base;
            r_head  <= n_head;
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_offset <= n_offset;
        if (w_accept) begin
            r_seq    <= i_in.pkt_seq;
            r_good   <= i_in.checksum_ok;
            r_eof    <= i_in.end_of_file;
            r_handle <= i_in.payload_handle;
            r_length <= i_in.payload_length;
        end
        if (w_load) begin
            r_okind   <= n_okind;
            r_oack    <= n_oack;
            r_ohandle <= n_ohandle;
            r_olength <= n_olength;
            r_olast   <= n_olast;
        end
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.kind       = r_okind;
    assign o_out.ack_seq    = r_oack;
    assign o_out.out_handle = r_ohandle;
    assign o_out.out_length = r_olength;
    assign o_out.last       = r_olast;

    // a delivery reads only a filled head slot
    a_dlv_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DLV) |-> w_rsp.filled[r_head])
        else $error("delivery from an empty slot");

    // a non-final result means the sequencer still has work for this header
    a_more_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_olast) |-> (r_state == S_DLV || r_state == S_BASE))
        else $error("non-final result with the sequencer idle");

    // base and head stay inside their ranges
    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (UNIT_W'(r_base) < UNIT_W'(SEQ_SPACE)) && (UNIT_W'(r_head) < UNIT_W'(WINDOW)))
        else $error("window base or head out of range");

    // the work path only runs on a good data header
    a_good_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OFF) |-> (r_good && !r_eof))
        else $error("offset step on a dropped or end-of-file header");

endmodule
